/* rtl/core/i2cms_pkg.sv */
// Shared types and constants for the I2C master bit sequencer core.
// Request payloads, configuration bundle, phase and mode codes.
// Depends on nothing; included first in compile order.
`timescale 1ns / 1ps

package i2cms_pkg;

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_START_SETUP = 3'd1,
    PH_START_HOLD  = 3'd2,
    PH_STOP_SETUP  = 3'd3,
    PH_STOP_HOLD   = 3'd4,
    PH_BIT_LOW     = 3'd5,
    PH_BIT_HIGH    = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    M_START = 3'd0,
    M_STOP  = 3'd1,
    M_WRITE = 3'd2,
    M_READ  = 3'd3,
    M_CHECK = 3'd4,
    M_ACK   = 3'd5,
    M_NACK  = 3'd6
  } mode_t;

  localparam int CfgIndexWidth = 2;

  localparam logic [CfgIndexWidth-1:0] CFG_BIT_HALF    = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_START_SETUP = 2'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_START_HOLD  = 2'd2;

  localparam logic [7:0] BIT_HALF_RESET    = 8'd5;
  localparam logic [7:0] START_SETUP_RESET = 8'd3;
  localparam logic [7:0] START_HOLD_RESET  = 8'd2;

  localparam logic [3:0] BYTE_BITS = 4'd8;
  localparam logic [3:0] ACK_BITS  = 4'd1;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] mode;
    logic [7:0] tx_byte;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_ok;
  } out_item_t;

  typedef struct packed {
    logic [7:0] bit_half_ticks;
    logic [7:0] start_setup_ticks;
    logic [7:0] start_hold_ticks;
  } cfg_t;

  // A zero timing register still holds the lines for one tick.
  function automatic logic [7:0] load_wait(input logic [7:0] r);
    return (r == 8'd0) ? 8'd1 : r;
  endfunction

endpackage

/* rtl/core/i2c_master_bit_sequencer_core.sv */
// I2C master bit sequencer core: an accepted tick request shows its result
// on the output register in the next cycle.
// Throughput: one tick per cycle; the output register frees itself when taken,
// so in_ready stays high as long as the result side keeps up.
// Reset (synchronous, active high): sequencer idle with SCL and SDA released,
// timing registers back to 5/3/2 ticks, output register empty. Uses i2cms_pkg.
`timescale 1ns / 1ps

module i2c_master_bit_sequencer_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  i2cms_pkg::in_item_t                   in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output i2cms_pkg::out_item_t                  out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [i2cms_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [7:0]                            cfg_data
);

  i2cms_pkg::cfg_t      cfg;
  i2cms_pkg::out_item_t step_result;
  logic                 advance;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign advance   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bit_half_ticks    <= i2cms_pkg::BIT_HALF_RESET;
      cfg.start_setup_ticks <= i2cms_pkg::START_SETUP_RESET;
      cfg.start_hold_ticks  <= i2cms_pkg::START_HOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        i2cms_pkg::CFG_BIT_HALF:    cfg.bit_half_ticks    <= cfg_data;
        i2cms_pkg::CFG_START_SETUP: cfg.start_setup_ticks <= cfg_data;
        i2cms_pkg::CFG_START_HOLD:  cfg.start_hold_ticks  <= cfg_data;
        default: begin
          // drop writes past the register list
        end
      endcase
    end
  end

  i2cms_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_data),
    .cfg     (cfg),
    .result  (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= step_result;
    end
  end

endmodule

/* rtl/core/i2cms_seq.sv */
// Bus sequencer: phase machine, wait and bit counters, shift register.
// Advances one tick per accepted request; result reflects the updated state.
// Depends on i2cms_pkg.
`timescale 1ns / 1ps

module i2cms_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  i2cms_pkg::in_item_t  item,
  input  i2cms_pkg::cfg_t      cfg,
  output i2cms_pkg::out_item_t result
);

  i2cms_pkg::phase_t phase, phase_next;
  i2cms_pkg::mode_t  active_mode, active_mode_next;
  logic [7:0] wait_count, wait_count_next;
  logic [3:0] bit_count, bit_count_next;
  logic [7:0] shift_reg, shift_reg_next;
  logic       scl_level, scl_level_next;
  logic       sda_level, sda_level_next;
  logic [7:0] rx_data, rx_data_next;
  logic       ack_flag, ack_flag_next;
  logic       done_next;

  logic       enter_low;
  logic [7:0] low_shift;
  logic [7:0] wait_dec;
  logic [7:0] shift_in;
  logic [3:0] bit_dec;

  assign wait_dec = wait_count - 8'd1;
  assign shift_in = {shift_reg[6:0], item.sda_in};
  assign bit_dec  = bit_count - 4'd1;

  // Next-state logic
  always_comb begin
    phase_next       = phase;
    active_mode_next = active_mode;
    wait_count_next  = wait_count;
    bit_count_next   = bit_count;
    shift_reg_next   = shift_reg;
    scl_level_next   = scl_level;
    sda_level_next   = sda_level;
    rx_data_next     = rx_data;
    ack_flag_next    = ack_flag;
    done_next        = 1'b0;
    enter_low        = 1'b0;
    low_shift        = shift_reg;

    if (phase == i2cms_pkg::PH_IDLE) begin
      if (item.cmd_valid && (item.mode <= i2cms_pkg::M_NACK)) begin
        active_mode_next = i2cms_pkg::mode_t'(item.mode);
        case (i2cms_pkg::mode_t'(item.mode))
          i2cms_pkg::M_START: begin
            sda_level_next  = 1'b1;
            scl_level_next  = 1'b1;
            phase_next      = i2cms_pkg::PH_START_SETUP;
            wait_count_next = i2cms_pkg::load_wait(cfg.start_setup_ticks);
          end
          i2cms_pkg::M_STOP: begin
            sda_level_next  = 1'b0;
            scl_level_next  = 1'b1;
            phase_next      = i2cms_pkg::PH_STOP_SETUP;
            wait_count_next = i2cms_pkg::load_wait(cfg.start_setup_ticks);
          end
          i2cms_pkg::M_WRITE: begin
            low_shift      = item.tx_byte;
            bit_count_next = i2cms_pkg::BYTE_BITS;
            enter_low      = 1'b1;
          end
          i2cms_pkg::M_READ: begin
            shift_reg_next = 8'h00;
            bit_count_next = i2cms_pkg::BYTE_BITS;
            enter_low      = 1'b1;
          end
          default: begin
            bit_count_next = i2cms_pkg::ACK_BITS;
            enter_low      = 1'b1;
          end
        endcase
      end
    end else begin
      wait_count_next = wait_dec;
      if (wait_dec == 8'd0) begin
        case (phase)
          i2cms_pkg::PH_START_SETUP: begin
            sda_level_next  = 1'b0;
            phase_next      = i2cms_pkg::PH_START_HOLD;
            wait_count_next = i2cms_pkg::load_wait(cfg.start_hold_ticks);
          end
          i2cms_pkg::PH_START_HOLD: begin
            scl_level_next = 1'b0;
            phase_next     = i2cms_pkg::PH_IDLE;
            done_next      = 1'b1;
          end
          i2cms_pkg::PH_STOP_SETUP: begin
            sda_level_next  = 1'b1;
            phase_next      = i2cms_pkg::PH_STOP_HOLD;
            wait_count_next = i2cms_pkg::load_wait(cfg.start_hold_ticks);
          end
          i2cms_pkg::PH_STOP_HOLD: begin
            phase_next = i2cms_pkg::PH_IDLE;
            done_next  = 1'b1;
          end
          i2cms_pkg::PH_BIT_LOW: begin
            scl_level_next  = 1'b1;
            phase_next      = i2cms_pkg::PH_BIT_HIGH;
            wait_count_next = i2cms_pkg::load_wait(cfg.bit_half_ticks);
          end
          i2cms_pkg::PH_BIT_HIGH: begin
            if (active_mode == i2cms_pkg::M_READ) begin
              shift_reg_next = shift_in;
            end else if (active_mode == i2cms_pkg::M_CHECK) begin
              ack_flag_next = ~item.sda_in;
            end
            bit_count_next = bit_dec;
            if (bit_dec == 4'd0) begin
              scl_level_next = 1'b0;
              if (active_mode == i2cms_pkg::M_READ) begin
                rx_data_next = shift_in;
              end
              phase_next = i2cms_pkg::PH_IDLE;
              done_next  = 1'b1;
            end else begin
              enter_low = 1'b1;
            end
          end
          default: begin
            phase_next = i2cms_pkg::PH_IDLE;
          end
        endcase
      end
    end

    // Drive the low half of a data or ack bit
    if (enter_low) begin
      scl_level_next = 1'b0;
      if (active_mode_next == i2cms_pkg::M_WRITE) begin
        sda_level_next = low_shift[7];
        shift_reg_next = {low_shift[6:0], 1'b0};
      end else if (active_mode_next == i2cms_pkg::M_ACK) begin
        sda_level_next = 1'b0;
      end else begin
        sda_level_next = 1'b1;
      end
      phase_next      = i2cms_pkg::PH_BIT_LOW;
      wait_count_next = i2cms_pkg::load_wait(cfg.bit_half_ticks);
    end
  end

  // Result logic
  always_comb begin
    result.scl_out  = scl_level_next;
    result.sda_out  = sda_level_next;
    result.busy_res = (phase_next != i2cms_pkg::PH_IDLE);
    result.done_res = done_next;
    result.rx_byte  = rx_data_next;
    result.ack_ok   = ack_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= i2cms_pkg::PH_IDLE;
      active_mode <= i2cms_pkg::M_START;
      wait_count  <= 8'd0;
      bit_count   <= 4'd0;
      shift_reg   <= 8'h00;
      scl_level   <= 1'b1;
      sda_level   <= 1'b1;
      rx_data     <= 8'h00;
      ack_flag    <= 1'b0;
    end else if (advance) begin
      phase       <= phase_next;
      active_mode <= active_mode_next;
      wait_count  <= wait_count_next;
      bit_count   <= bit_count_next;
      shift_reg   <= shift_reg_next;
      scl_level   <= scl_level_next;
      sda_level   <= sda_level_next;
      rx_data     <= rx_data_next;
      ack_flag    <= ack_flag_next;
    end
  end

  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    (advance && done_next) |=> (phase == i2cms_pkg::PH_IDLE))
    else $error("done reported without returning to idle");

  a_busy_ignores_cmd: assert property (@(posedge clk) disable iff (rst)
    (advance && (phase != i2cms_pkg::PH_IDLE)) |=> (active_mode == $past(active_mode)))
    else $error("command taken while busy");

  a_wait_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase != i2cms_pkg::PH_IDLE) |-> (wait_count != 8'd0))
    else $error("wait counter empty in an active phase");

  a_bit_count_range: assert property (@(posedge clk) disable iff (rst)
    ((phase == i2cms_pkg::PH_BIT_LOW) || (phase == i2cms_pkg::PH_BIT_HIGH))
      |-> ((bit_count != 4'd0) && (bit_count <= i2cms_pkg::BYTE_BITS)))
    else $error("bit counter out of range during a bit");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(phase) && $stable(wait_count) && $stable(shift_reg)))
    else $error("sequencer state moved without a request");

endmodule
